// File: src/eegsp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eegsp_pkg
// Shared constants, types and controller/datapath signal groups for the
// EEG serial packet parser.
// ---------------------------------------------------------------------------
package eegsp_pkg;

  // payload buffer depth and band count
  localparam int PAYLOAD_DEPTH = 64;
  localparam int BAND_COUNT    = 8;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int BAND_W        = $clog2(BAND_COUNT);

  localparam logic [7:0] DEPTH_BYTE = 8'(PAYLOAD_DEPTH);

  // framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'd170;

  // row codes
  localparam logic [7:0] ROW_QUALITY    = 8'h02;
  localparam logic [7:0] ROW_ATTENTION  = 8'h04;
  localparam logic [7:0] ROW_MEDITATION = 8'h05;
  localparam logic [7:0] ROW_BANDS      = 8'h83;
  localparam logic [7:0] ROW_RAW        = 8'h80;

  // row sizes: bytes past the code that must lie inside the payload
  localparam logic [7:0] VALUE_ROW_REACH = 8'd1;
  localparam logic [7:0] RAW_ROW_REACH   = 8'd3;
  localparam logic [7:0] BAND_ROW_REACH  = 8'(1 + 3 * BAND_COUNT);

  // pointer steps
  localparam logic [2:0] STEP_CODE   = 3'd1;
  localparam logic [2:0] STEP_HEADER = 3'd2;
  localparam logic [2:0] STEP_RAW    = 3'd4;

  // bytes per band power, counted from zero
  localparam logic [1:0] BAND_BYTE_LAST = 2'd2;
  localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BAND_COUNT - 1);

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SUM   = 2'd1;
  localparam logic [1:0] STATUS_PARSE = 2'd2;
  localparam logic [1:0] STATUS_LONG  = 2'd3;

  typedef enum logic [2:0] {
    ST_RECV,
    ST_CODE,
    ST_VALUE,
    ST_BAND,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RX_NONE,
    RX_TOO_LONG,
    RX_BAD_SUM,
    RX_GOOD_SUM
  } rx_event_t;

  typedef enum logic [1:0] {
    CODE_VALUE,
    CODE_BANDS,
    CODE_RAW,
    CODE_OTHER
  } code_kind_t;

  // controller to datapath
  typedef struct packed {
    logic       rx_accept;
    logic       walk_start;
    logic       err_long;
    logic       err_sum;
    logic       err_parse;
    logic [2:0] ptr_add;
    logic       save_code;
    logic       write_value;
    logic       band_begin;
    logic       band_shift;
    logic       emit_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    rx_event_t  rx_event;
    logic       walk_end;
    code_kind_t code_kind;
    logic       row_fits;
    logic       band_done;
    logic       out_free;
    logic       emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/eegsp_byte_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eegsp_byte_if
// Input channel: one received serial byte per word.
// ---------------------------------------------------------------------------
interface eegsp_byte_if;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);

endinterface

`default_nettype wire

// File: src/eegsp_result_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eegsp_result_if
// Output channel: one parsed packet result per word.
// ---------------------------------------------------------------------------
interface eegsp_result_if;

  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  signal_quality;
  logic [7:0]  attention_level;
  logic [7:0]  meditation_level;
  logic        power_valid;
  logic [2:0]  band_index;
  logic [23:0] band_power;
  logic        last;

  modport source (
    output valid, output status, output signal_quality, output attention_level,
    output meditation_level, output power_valid, output band_index,
    output band_power, output last, input ready
  );
  modport sink (
    input valid, input status, input signal_quality, input attention_level,
    input meditation_level, input power_valid, input band_index,
    input band_power, input last, output ready
  );

endinterface

`default_nettype wire

// File: src/eegsp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eegsp_ctrl
// Sequencer for byte reception, the row-by-row payload walk and result
// emission.
// ---------------------------------------------------------------------------
module eegsp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   rx_valid,
  output logic                        rx_ready,
  input  eegsp_pkg::dp_status_t       dp_status,
  output eegsp_pkg::ctrl_cmd_t        cmd
);
  import eegsp_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RECV: begin
        if (rx_valid) begin
          case (dp_status.rx_event)
            RX_TOO_LONG: state_next = ST_EMIT;
            RX_BAD_SUM:  state_next = ST_EMIT;
            RX_GOOD_SUM: state_next = ST_CODE;
            default:     state_next = ST_RECV;
          endcase
        end
      end
      ST_CODE: begin
        if (dp_status.walk_end) begin
          state_next = ST_EMIT;
        end else begin
          case (dp_status.code_kind)
            CODE_VALUE: state_next = dp_status.row_fits ? ST_VALUE : ST_EMIT;
            CODE_BANDS: state_next = dp_status.row_fits ? ST_BAND : ST_EMIT;
            CODE_RAW:   state_next = dp_status.row_fits ? ST_CODE : ST_EMIT;
            default:    state_next = ST_CODE;
          endcase
        end
      end
      ST_VALUE: state_next = ST_CODE;
      ST_BAND: begin
        if (dp_status.band_done) begin
          state_next = ST_CODE;
        end
      end
      ST_EMIT: begin
        if (dp_status.out_free && dp_status.emit_last) begin
          state_next = ST_RECV;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    rx_ready = 1'b0;
    case (state)
      ST_RECV: begin
        rx_ready      = 1'b1;
        cmd.rx_accept = rx_valid;
        if (rx_valid) begin
          case (dp_status.rx_event)
            RX_TOO_LONG: cmd.err_long   = 1'b1;
            RX_BAD_SUM:  cmd.err_sum    = 1'b1;
            RX_GOOD_SUM: cmd.walk_start = 1'b1;
            default:     cmd.walk_start = 1'b0;
          endcase
        end
      end
      ST_CODE: begin
        if (!dp_status.walk_end) begin
          case (dp_status.code_kind)
            CODE_VALUE: begin
              if (dp_status.row_fits) begin
                cmd.save_code = 1'b1;
                cmd.ptr_add   = STEP_CODE;
              end else begin
                cmd.err_parse = 1'b1;
              end
            end
            CODE_BANDS: begin
              if (dp_status.row_fits) begin
                cmd.band_begin = 1'b1;
                cmd.ptr_add    = STEP_HEADER;
              end else begin
                cmd.err_parse = 1'b1;
              end
            end
            CODE_RAW: begin
              if (dp_status.row_fits) begin
                cmd.ptr_add = STEP_RAW;
              end else begin
                cmd.err_parse = 1'b1;
              end
            end
            default: begin
              // unknown code: flag it and step over one byte
              cmd.err_parse = 1'b1;
              cmd.ptr_add   = STEP_CODE;
            end
          endcase
        end
      end
      ST_VALUE: begin
        cmd.write_value = 1'b1;
        cmd.ptr_add     = STEP_CODE;
      end
      ST_BAND: cmd.band_shift = 1'b1;
      ST_EMIT: cmd.emit_load = dp_status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/eegsp_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eegsp_datapath
// Frame tracking, payload buffer, held values, band power store and the
// result output register.
// ---------------------------------------------------------------------------
module eegsp_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             rx_byte,
  input  eegsp_pkg::ctrl_cmd_t        cmd,
  output eegsp_pkg::dp_status_t       dp_status,
  eegsp_result_if.source              result_out
);
  import eegsp_pkg::*;

  // receive state
  logic       in_frame;
  logic [7:0] previous_byte;
  logic [7:0] frame_position;
  logic [7:0] payload_length;
  logic [7:0] running_sum;

  // payload buffer
  logic [7:0]        payload_store [PAYLOAD_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  // walk state
  logic [7:0]        ptr;
  logic [7:0]        ptr_next;
  logic [7:0]        saved_code;
  logic [15:0]       band_acc;
  logic [1:0]        band_byte;
  logic [BAND_W-1:0] band_sel;
  logic [1:0]        status_reg;

  // held values and band powers
  logic [7:0]  quality_reg;
  logic [7:0]  attention_reg;
  logic [7:0]  meditation_reg;
  logic [23:0] band_store [BAND_COUNT];
  logic        bands_present;

  // emission
  logic [BAND_W-1:0] emit_idx;
  logic              out_valid;
  logic              out_free;
  logic              emit_last;

  // status toward the controller
  rx_event_t  rx_event;
  code_kind_t code_kind;
  logic       row_fits;
  logic       walk_end;
  logic       band_done;

  // receive event for the byte on the input
  always_comb begin
    rx_event = RX_NONE;
    if (in_frame) begin
      if (frame_position == 8'd0) begin
        if (rx_byte > DEPTH_BYTE) begin
          rx_event = RX_TOO_LONG;
        end
      end else if (frame_position > payload_length) begin
        rx_event = (rx_byte == ~running_sum) ? RX_GOOD_SUM : RX_BAD_SUM;
      end
    end
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      previous_byte  <= 8'd0;
      frame_position <= 8'd0;
      payload_length <= 8'd0;
      running_sum    <= 8'd0;
    end else if (cmd.rx_accept) begin
      previous_byte <= rx_byte;
      if (!in_frame) begin
        if (rx_byte == SYNC_BYTE && previous_byte == SYNC_BYTE) begin
          in_frame       <= 1'b1;
          frame_position <= 8'd0;
          running_sum    <= 8'd0;
        end
      end else begin
        frame_position <= frame_position + 8'd1;
        if (frame_position == 8'd0) begin
          payload_length <= rx_byte;
          if (rx_byte > DEPTH_BYTE) begin
            in_frame <= 1'b0;
          end
        end else if (frame_position <= payload_length) begin
          running_sum <= running_sum + rx_byte;
        end else begin
          in_frame <= 1'b0;
        end
      end
    end
  end

  // payload buffer: write on payload bytes, registered read at next pointer
  assign wr_addr = ADDR_W'(frame_position - 8'd1);
  assign rd_addr = (ptr_next < DEPTH_BYTE) ? ADDR_W'(ptr_next) : '0;

  always_ff @(posedge clk) begin
    if (cmd.rx_accept && in_frame && frame_position != 8'd0 &&
        frame_position <= payload_length) begin
      payload_store[wr_addr] <= rx_byte;
    end
    rd_data <= payload_store[rd_addr];
  end

  // walk pointer
  always_comb begin
    ptr_next = ptr;
    if (cmd.walk_start) begin
      ptr_next = 8'd0;
    end else if (cmd.band_shift) begin
      ptr_next = ptr + 8'd1;
    end else begin
      ptr_next = ptr + 8'(cmd.ptr_add);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= 8'd0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // row classification and bounds
  always_comb begin
    case (rd_data)
      ROW_QUALITY:    code_kind = CODE_VALUE;
      ROW_ATTENTION:  code_kind = CODE_VALUE;
      ROW_MEDITATION: code_kind = CODE_VALUE;
      ROW_BANDS:      code_kind = CODE_BANDS;
      ROW_RAW:        code_kind = CODE_RAW;
      default:        code_kind = CODE_OTHER;
    endcase
    case (code_kind)
      CODE_VALUE: row_fits = (ptr + VALUE_ROW_REACH) < payload_length;
      CODE_BANDS: row_fits = (ptr + BAND_ROW_REACH) < payload_length;
      CODE_RAW:   row_fits = (ptr + RAW_ROW_REACH) < payload_length;
      default:    row_fits = 1'b1;
    endcase
  end

  assign walk_end  = ptr >= payload_length;
  assign band_done = (band_byte == BAND_BYTE_LAST) && (band_sel == BAND_LAST);

  // status of the packet being finished
  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg <= STATUS_OK;
    end else if (cmd.walk_start) begin
      status_reg <= STATUS_OK;
    end else if (cmd.err_long) begin
      status_reg <= STATUS_LONG;
    end else if (cmd.err_sum) begin
      status_reg <= STATUS_SUM;
    end else if (cmd.err_parse) begin
      status_reg <= STATUS_PARSE;
    end
  end

  // single-value rows
  always_ff @(posedge clk) begin
    if (rst) begin
      quality_reg    <= 8'd200;
      attention_reg  <= 8'd0;
      meditation_reg <= 8'd0;
    end else if (cmd.write_value) begin
      case (saved_code)
        ROW_QUALITY:    quality_reg    <= rd_data;
        ROW_ATTENTION:  attention_reg  <= rd_data;
        ROW_MEDITATION: meditation_reg <= rd_data;
        default:        quality_reg    <= quality_reg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_code) begin
      saved_code <= rd_data;
    end
  end

  // band power row: three bytes per band, big-endian
  always_ff @(posedge clk) begin
    if (rst) begin
      bands_present <= 1'b0;
      band_byte     <= 2'd0;
      band_sel      <= '0;
      for (int b = 0; b < BAND_COUNT; b++) begin
        band_store[b] <= 24'd0;
      end
    end else if (cmd.walk_start || cmd.err_long || cmd.err_sum) begin
      bands_present <= 1'b0;
      for (int b = 0; b < BAND_COUNT; b++) begin
        band_store[b] <= 24'd0;
      end
    end else if (cmd.band_begin) begin
      bands_present <= 1'b1;
      band_byte     <= 2'd0;
      band_sel      <= '0;
    end else if (cmd.band_shift) begin
      if (band_byte == BAND_BYTE_LAST) begin
        band_store[band_sel] <= {band_acc, rd_data};
        band_byte            <= 2'd0;
        band_sel             <= band_sel + BAND_W'(1);
      end else begin
        band_byte <= band_byte + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.band_shift) begin
      band_acc <= {band_acc[7:0], rd_data};
    end
  end

  // result emission
  assign out_free  = !out_valid || result_out.ready;
  assign emit_last = !bands_present || (emit_idx == BAND_LAST);

  assign dp_status = {rx_event, walk_end, code_kind, row_fits, band_done,
                      out_free, emit_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.walk_start || cmd.err_long || cmd.err_sum) begin
        emit_idx <= '0;
      end else if (cmd.emit_load) begin
        emit_idx <= emit_idx + BAND_W'(1);
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result_out.status           <= status_reg;
      result_out.signal_quality   <= quality_reg;
      result_out.attention_level  <= attention_reg;
      result_out.meditation_level <= meditation_reg;
      result_out.power_valid      <= bands_present;
      result_out.band_index       <= bands_present ? 3'(emit_idx) : 3'd0;
      result_out.band_power       <= bands_present ? band_store[emit_idx] : 24'd0;
      result_out.last             <= emit_last;
    end
  end

  assign result_out.valid = out_valid;

endmodule

`default_nettype wire

// File: src/eeg_serial_packet_parser_core.sv
`default_nettype none
// A byte that does not end a packet is taken in the cycle it is offered.
// A packet ending in an error loads its result word after the ending byte, once the output register is free;
// a good packet walks its payload row by row through the one read port of the payload
// buffer, then emits one result word per cycle while the output register is free.
// Input ready stays low from the packet-ending byte until the last result word is loaded.
// Reset (rst, synchronous): out of frame, quality 200, other held values and bands zero.
// ---------------------------------------------------------------------------
// eeg_serial_packet_parser_core
// Top level: parses a serial EEG headset byte stream into packet results.
// ---------------------------------------------------------------------------
module eeg_serial_packet_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  eegsp_byte_if.sink       byte_in,
  eegsp_result_if.source   result_out
);
  import eegsp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencer
  eegsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (byte_in.valid),
    .rx_ready  (byte_in.ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // datapath
  eegsp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (byte_in.data_byte),
    .cmd        (cmd),
    .dp_status  (dp_status),
    .result_out (result_out)
  );

endmodule

`default_nettype wire
